// File: rtl/odrc_pkg.sv
// Package for the omni drive ramp controller: types, codes, reset values
// and the small per-tick helper functions. No dependencies.
package odrc_pkg;

	localparam logic [7:0]  RESET_BASE_DUTY      = 8'd190;
	localparam logic [7:0]  RESET_SPEED_STEP     = 8'd1;
	localparam logic [7:0]  RESET_TURN_STEP      = 8'd2;
	localparam logic [7:0]  RESET_SPEED_CEIL     = 8'd255 - RESET_BASE_DUTY;
	localparam logic [15:0] RESET_BLINK_PERIOD   = 16'd250;

	// Configuration register indexes.
	localparam int          CFG_INDEX_W          = 3;
	localparam int          CFG_DATA_W           = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_DUTY      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_STEP     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TURN_STEP      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CEIL     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TURN_SPEED = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD   = 3'd5;

	// Remote command bytes.
	localparam logic [7:0] CMD_MOVE_FIRST = 8'h31;
	localparam logic [7:0] CMD_MOVE_LAST  = 8'h38;
	localparam logic [7:0] CMD_TURN_CCW   = 8'h39;
	localparam logic [7:0] CMD_TURN_CW    = 8'h61;
	localparam logic [7:0] CMD_MOVE_STOP  = 8'h62;
	localparam logic [7:0] CMD_TURN_STOP  = 8'h63;
	localparam logic [7:0] CMD_EMERGENCY  = 8'h7A;

	// Pin patterns for spinning in place.
	localparam logic [7:0] PINS_TURN_CW  = 8'h99;
	localparam logic [7:0] PINS_TURN_CCW = 8'h66;

	// Light bits.
	localparam int L_HEAD  = 0;
	localparam int L_TAIL  = 1;
	localparam int L_BRAKE = 2;
	localparam int L_LEFT  = 3;
	localparam int L_RIGHT = 4;

	// Blink timers.
	localparam int T_LEFT_IND  = 0;
	localparam int T_RIGHT_IND = 1;
	localparam int T_EMERG     = 2;

	typedef enum logic [3:0] {
		MOVE_IDLE, MOVE_FWD_LEFT, MOVE_FWD, MOVE_FWD_RIGHT, MOVE_LEFT,
		MOVE_RIGHT, MOVE_BACK_LEFT, MOVE_BACK, MOVE_BACK_RIGHT
	} move_t;

	// Spinning left is counterclockwise, spinning right is clockwise.
	typedef enum logic [1:0] {
		TURN_NONE, TURN_CCW, TURN_CW
	} turn_t;

	typedef struct packed {
		logic [7:0]  base_duty;
		logic [7:0]  speed_step;
		logic [7:0]  turn_step;
		logic [7:0]  speed_ceil;
		logic [7:0]  max_turn_speed;
		logic [15:0] blink_period_ms;
	} cfg_t;

	typedef struct packed {
		logic             emergency;
		move_t            move_dir;
		move_t            pending_move_dir;
		turn_t            turn_dir;
		turn_t            pending_turn_dir;
		logic [7:0]       speed;
		logic [7:0]       turn_speed;
		logic [4:0]       lights;
		logic [2:0][31:0] blink_start;
		logic [2:0]       blink_armed;
		logic [7:0]       pin;
		logic [7:0]       duty;
	} state_t;

	function automatic logic timer_due(logic armed, logic [31:0] start, logic [31:0] now,
			logic [15:0] period);
		logic [31:0] diff;
		diff = now - start;
		return !armed || (diff >= {16'd0, period});
	endfunction

	// From standstill the first step is taken without the ceiling check.
	function automatic logic [7:0] ramp_up(logic [7:0] v, logic [7:0] step, logic [7:0] ceil);
		logic [8:0] n;
		n = {1'b0, v} + {1'b0, step};
		if (v == 8'd0) return step;
		return (n >= {1'b0, ceil}) ? ceil : n[7:0];
	endfunction

	function automatic logic [7:0] ramp_down(logic [7:0] v, logic [7:0] step);
		return (step >= v) ? 8'd0 : v - step;
	endfunction

	function automatic logic [7:0] sat_duty(logic [7:0] base, logic [7:0] r);
		logic [8:0] d;
		d = {1'b0, base} + {1'b0, r};
		return d[8] ? 8'hFF : d[7:0];
	endfunction

	function automatic logic [7:0] move_pins(move_t m);
		logic [7:0] p;
		case (m)
			MOVE_IDLE:       p = 8'h00;
			MOVE_FWD_LEFT:   p = 8'h50;
			MOVE_FWD:        p = 8'h55;
			MOVE_FWD_RIGHT:  p = 8'h05;
			MOVE_LEFT:       p = 8'h5A;
			MOVE_RIGHT:      p = 8'hA5;
			MOVE_BACK_LEFT:  p = 8'h0A;
			MOVE_BACK:       p = 8'hAA;
			MOVE_BACK_RIGHT: p = 8'hA0;
			default:         p = 8'h00;
		endcase
		return p;
	endfunction

	// Entering emergency stops everything; leaving it restores head and tail.
	function automatic state_t emergency_toggle(state_t s, cfg_t c);
		state_t r;
		r = s;
		r.emergency = !s.emergency;
		if (r.emergency) begin
			r.pin              = 8'd0;
			r.duty             = c.base_duty;
			r.speed            = 8'd0;
			r.turn_speed       = 8'd0;
			r.move_dir         = MOVE_IDLE;
			r.pending_move_dir = MOVE_IDLE;
			r.turn_dir         = TURN_NONE;
			r.pending_turn_dir = TURN_NONE;
		end else begin
			r.blink_armed[T_EMERG] = 1'b0;
			r.lights[L_HEAD]       = 1'b1;
			r.lights[L_TAIL]       = 1'b1;
		end
		return r;
	endfunction

	function automatic state_t emergency_blink(state_t s, logic [31:0] now, logic [15:0] period);
		state_t r;
		r = s;
		if (timer_due(s.blink_armed[T_EMERG], s.blink_start[T_EMERG], now, period)) begin
			r.lights[L_HEAD]       = !s.lights[L_HEAD];
			r.lights[L_TAIL]       = !s.lights[L_TAIL];
			r.blink_start[T_EMERG] = now;
			r.blink_armed[T_EMERG] = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: rtl/odrc_tick_if.sv
// Tick channel of the omni drive ramp controller: valid/ready plus the
// tick fields. No dependencies.
interface odrc_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        button_pressed;
	logic        cmd_valid;
	logic [7:0]  cmd;

	modport source (output valid, output now_ms, output button_pressed, output cmd_valid,
		output cmd, input ready);
	modport sink (input valid, input now_ms, input button_pressed, input cmd_valid,
		input cmd, output ready);
endinterface

// File: rtl/odrc_result_if.sv
// Result channel of the omni drive ramp controller: valid/ready plus the
// motor and light outputs. No dependencies.
interface odrc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] motor_pins;
	logic [7:0] duty;
	logic       head_light;
	logic       tail_light;
	logic       brake_light;
	logic       left_indicator;
	logic       right_indicator;
	logic       emergency_active;

	modport source (output valid, output motor_pins, output duty, output head_light,
		output tail_light, output brake_light, output left_indicator,
		output right_indicator, output emergency_active, input ready);
	modport sink (input valid, input motor_pins, input duty, input head_light,
		input tail_light, input brake_light, input left_indicator,
		input right_indicator, input emergency_active, output ready);
endinterface

// File: rtl/odrc_step.sv
// Next-state logic for one control tick: emergency, lighting, ramps and
// command decode. Depends on odrc_pkg.
module odrc_step
	import odrc_pkg::*;
(
	input  state_t      st,
	input  cfg_t        cfg,
	input  logic [31:0] now_ms,
	input  logic        button_pressed,
	input  logic        cmd_valid,
	input  logic [7:0]  cmd,
	output state_t      nx
);

	always_comb begin
		state_t s;
		logic   lwant;
		logic   rwant;
		s = st;
		lwant = 1'b0;
		rwant = 1'b0;

		if (button_pressed) s = emergency_toggle(s, cfg);

		if (s.emergency) begin
			s = emergency_blink(s, now_ms, cfg.blink_period_ms);
		end else begin
			// Lighting uses the directions as they stood at the start of the tick.
			lwant = (s.turn_dir == TURN_CCW) || (s.move_dir inside
				{MOVE_LEFT, MOVE_FWD_LEFT, MOVE_BACK_LEFT});
			rwant = (s.turn_dir == TURN_CW) || (s.move_dir inside
				{MOVE_RIGHT, MOVE_FWD_RIGHT, MOVE_BACK_RIGHT});
			if (lwant && timer_due(s.blink_armed[T_LEFT_IND], s.blink_start[T_LEFT_IND],
					now_ms, cfg.blink_period_ms)) begin
				s.lights[L_LEFT]          = !s.lights[L_LEFT];
				s.blink_start[T_LEFT_IND] = now_ms;
				s.blink_armed[T_LEFT_IND] = 1'b1;
			end else if (rwant && timer_due(s.blink_armed[T_RIGHT_IND],
					s.blink_start[T_RIGHT_IND], now_ms, cfg.blink_period_ms)) begin
				s.lights[L_RIGHT]          = !s.lights[L_RIGHT];
				s.blink_start[T_RIGHT_IND] = now_ms;
				s.blink_armed[T_RIGHT_IND] = 1'b1;
			end
			if (s.turn_dir != TURN_CCW && s.pending_turn_dir != TURN_CCW) begin
				s.lights[L_LEFT]          = 1'b0;
				s.blink_armed[T_LEFT_IND] = 1'b0;
			end
			if (s.turn_dir != TURN_CW && s.pending_turn_dir != TURN_CW) begin
				s.lights[L_RIGHT]          = 1'b0;
				s.blink_armed[T_RIGHT_IND] = 1'b0;
			end
			s.lights[L_BRAKE] = (s.pending_move_dir != s.move_dir);

			// Ramps: a pending change first brings its speed down to zero.
			if (s.pending_turn_dir != s.turn_dir) begin
				s.turn_speed = ramp_down(s.turn_speed, cfg.turn_step);
			end else if (s.turn_dir != TURN_NONE) begin
				s.turn_speed = ramp_up(s.turn_speed, cfg.turn_step, cfg.max_turn_speed);
			end

			case (s.pending_turn_dir)
				TURN_NONE: begin
					if (s.pending_move_dir != s.move_dir) begin
						s.speed = ramp_down(s.speed, cfg.speed_step);
					end else if (s.move_dir != MOVE_IDLE) begin
						s.speed = ramp_up(s.speed, cfg.speed_step, cfg.speed_ceil);
					end
					s.pin  = move_pins(s.pending_move_dir);
					s.duty = (s.pending_move_dir == MOVE_IDLE) ? cfg.base_duty :
						sat_duty(cfg.base_duty, s.speed);
					if (s.speed == 8'd0) s.move_dir = s.pending_move_dir;
				end
				TURN_CW: begin
					s.pin  = PINS_TURN_CW;
					s.duty = sat_duty(cfg.base_duty, s.turn_speed);
				end
				TURN_CCW: begin
					s.pin  = PINS_TURN_CCW;
					s.duty = sat_duty(cfg.base_duty, s.turn_speed);
				end
				default: ;
			endcase
			if (s.turn_speed == 8'd0) s.turn_dir = s.pending_turn_dir;

			if (cmd_valid) begin
				if (cmd inside {[CMD_MOVE_FIRST:CMD_MOVE_LAST]}) begin
					s.pending_move_dir = move_t'(cmd[3:0]);
				end else if (cmd == CMD_TURN_CCW) begin
					s.pending_turn_dir = TURN_CCW;
				end else if (cmd == CMD_TURN_CW) begin
					s.pending_turn_dir = TURN_CW;
				end else if (cmd == CMD_MOVE_STOP) begin
					s.pending_move_dir = MOVE_IDLE;
				end else if (cmd == CMD_TURN_STOP) begin
					s.pending_turn_dir = TURN_NONE;
				end else if (cmd == CMD_EMERGENCY) begin
					// Entry from a command flashes head and tail on the same tick.
					s = emergency_toggle(s, cfg);
					s = emergency_blink(s, now_ms, cfg.blink_period_ms);
				end
			end
		end
		nx = s;
	end

endmodule

// File: rtl/omni_drive_ramp_controller.sv
// Top level of the omni drive ramp controller: tick input register,
// controller state, configuration registers and result register.
// Depends on odrc_pkg, odrc_tick_if, odrc_result_if and odrc_step.

// Each request on the tick channel is one control tick and yields exactly one
// result: the eight H-bridge pins, the common PWM duty, the five lights and the
// emergency flag. A tick is captured in an input register, the next controller
// state is formed in combinational logic, and the result is held in an output
// register; one tick is taken per clock cycle while the result side is not
// stalled, and a result is loaded into the output register when its tick
// advances out of the input register. While a result waits, the input
// register still takes one more tick. Configuration writes
// (index 0 base duty, 1 speed step, 2 turn step, 3 speed ceiling, 4 turn
// ceiling, 5 blink period in ms) act on the ticks that follow them and should
// be made while no tick is in flight. Indexes 6 and 7 are ignored.
module omni_drive_ramp_controller
	import odrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	odrc_tick_if.sink              tick,
	odrc_result_if.source          result
);

	cfg_t        cfg_q;
	state_t      state_q;
	state_t      state_nx;

	logic        valid_s1;
	logic [31:0] now_s1;
	logic        button_s1;
	logic        cmd_valid_s1;
	logic [7:0]  cmd_s1;

	logic        res_valid_q;
	logic [7:0]  pins_q;
	logic [7:0]  duty_q;
	logic [4:0]  lights_q;
	logic        emergency_q;

	logic        advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_duty       <= RESET_BASE_DUTY;
			cfg_q.speed_step      <= RESET_SPEED_STEP;
			cfg_q.turn_step       <= RESET_TURN_STEP;
			cfg_q.speed_ceil      <= RESET_SPEED_CEIL;
			cfg_q.max_turn_speed  <= RESET_SPEED_CEIL;
			cfg_q.blink_period_ms <= RESET_BLINK_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_DUTY:      cfg_q.base_duty       <= cfg_data[7:0];
				REG_SPEED_STEP:     cfg_q.speed_step      <= cfg_data[7:0];
				REG_TURN_STEP:      cfg_q.turn_step       <= cfg_data[7:0];
				REG_SPEED_CEIL:     cfg_q.speed_ceil      <= cfg_data[7:0];
				REG_MAX_TURN_SPEED: cfg_q.max_turn_speed  <= cfg_data[7:0];
				REG_BLINK_PERIOD:   cfg_q.blink_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			now_s1       <= tick.now_ms;
			button_s1    <= tick.button_pressed;
			cmd_valid_s1 <= tick.cmd_valid;
			cmd_s1       <= tick.cmd;
		end
	end

	odrc_step u_step (
		.st             (state_q),
		.cfg            (cfg_q),
		.now_ms         (now_s1),
		.button_pressed (button_s1),
		.cmd_valid      (cmd_valid_s1),
		.cmd            (cmd_s1),
		.nx             (state_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.emergency        <= 1'b0;
			state_q.move_dir         <= MOVE_IDLE;
			state_q.pending_move_dir <= MOVE_IDLE;
			state_q.turn_dir         <= TURN_NONE;
			state_q.pending_turn_dir <= TURN_NONE;
			state_q.speed            <= 8'd0;
			state_q.turn_speed       <= 8'd0;
			state_q.lights           <= 5'((1 << L_HEAD) | (1 << L_TAIL));
			state_q.blink_start      <= '0;
			state_q.blink_armed      <= '0;
			state_q.pin              <= 8'd0;
			state_q.duty             <= RESET_BASE_DUTY;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pins_q      <= state_nx.pin;
			duty_q      <= state_nx.duty;
			lights_q    <= state_nx.lights;
			emergency_q <= state_nx.emergency;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.motor_pins       = pins_q;
	assign result.duty             = duty_q;
	assign result.head_light       = lights_q[L_HEAD];
	assign result.tail_light       = lights_q[L_TAIL];
	assign result.brake_light      = lights_q[L_BRAKE];
	assign result.left_indicator   = lights_q[L_LEFT];
	assign result.right_indicator  = lights_q[L_RIGHT];
	assign result.emergency_active = emergency_q;

	// Emergency mode holds the motors stopped with both ramps at zero.
	a_emergency_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.emergency |-> (state_q.pin == 8'd0 && state_q.speed == 8'd0 &&
			state_q.turn_speed == 8'd0))
		else $error("motors not stopped in emergency mode");

	// The emergency blink timer is disarmed whenever emergency mode is off.
	a_emerg_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.emergency |-> !state_q.blink_armed[T_EMERG])
		else $error("emergency blink timer armed outside emergency mode");

	// A tick held in the input register is neither lost nor altered.
	a_tick_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(now_s1) && $stable(cmd_s1)))
		else $error("stalled tick dropped or overwritten");

	// Every processed tick leaves a result in the output register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed tick produced no result");

endmodule

// File: sim/omni_drive_ramp_controller_tb.sv
// Self-checking testbench for the omni drive ramp controller: directed and random ticks
// through the tick and result channels, each result checked against a behavioral model.
// Depends on odrc_pkg, odrc_tick_if, odrc_result_if and omni_drive_ramp_controller.
module omni_drive_ramp_controller_tb;
	import odrc_pkg::*;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        button_pressed;
		logic        cmd_valid;
		logic [7:0]  cmd;
	} tick_req_t;

	typedef struct packed {
		logic [7:0] motor_pins;
		logic [7:0] duty;
		logic       head_light;
		logic       tail_light;
		logic       brake_light;
		logic       left_indicator;
		logic       right_indicator;
		logic       emergency_active;
	} drive_res_t;

	typedef struct packed {
		logic [7:0]  base_duty;
		logic [7:0]  speed_step;
		logic [7:0]  turn_step;
		logic [7:0]  speed_ceil;
		logic [7:0]  max_turn_speed;
		logic [15:0] blink_period;
	} setting_t;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_BLINK_PERIOD + 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = REG_BLINK_PERIOD + 3'd2;

	// H-bridge patterns, indexed by move direction.
	localparam logic [7:0] MOVE_PATTERN [9] = '{
		8'h00, 8'h50, 8'h55, 8'h05, 8'h5A, 8'hA5, 8'h0A, 8'hAA, 8'hA0
	};

	localparam tick_req_t DIRECTED_TICKS [25] = '{
		'{32'd0,         1'b0, 1'b0, 8'h00},
		'{32'd20,        1'b0, 1'b1, CMD_MOVE_FIRST + 8'd1},
		'{32'd40,        1'b0, 1'b0, 8'hA5},
		'{32'd60,        1'b0, 1'b1, CMD_TURN_CCW},
		'{32'd80,        1'b0, 1'b0, 8'h00},
		'{32'd300,       1'b0, 1'b1, CMD_TURN_CW},
		'{32'd320,       1'b0, 1'b1, CMD_MOVE_FIRST},
		'{32'd340,       1'b0, 1'b1, CMD_TURN_STOP},
		'{32'd360,       1'b0, 1'b1, CMD_MOVE_FIRST + 8'd2},
		'{32'd380,       1'b0, 1'b1, CMD_MOVE_FIRST + 8'd3},
		'{32'd400,       1'b0, 1'b1, CMD_MOVE_FIRST + 8'd4},
		'{32'd420,       1'b0, 1'b1, CMD_MOVE_FIRST + 8'd5},
		'{32'd440,       1'b0, 1'b1, CMD_MOVE_FIRST + 8'd6},
		'{32'd460,       1'b0, 1'b1, CMD_MOVE_LAST},
		'{32'd480,       1'b0, 1'b1, CMD_MOVE_STOP},
		'{32'd500,       1'b0, 1'b1, 8'h30},
		'{32'd520,       1'b0, 1'b1, 8'hFF},
		'{32'hFFFF_FFF0, 1'b0, 1'b1, CMD_EMERGENCY},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, CMD_EMERGENCY},
		'{32'h0000_00F0, 1'b0, 1'b0, 8'h00},
		'{32'h0000_0100, 1'b1, 1'b1, CMD_MOVE_FIRST + 8'd1},
		'{32'h0000_0120, 1'b1, 1'b0, 8'h00},
		'{32'h0000_0140, 1'b1, 1'b1, CMD_EMERGENCY},
		'{32'h0000_0160, 1'b1, 1'b0, 8'h00},
		'{32'h0000_0180, 1'b0, 1'b1, 8'h00}
	};

	// Tracks the controller state tick by tick and holds the results still owed.
	class drive_tracker;
		setting_t    cfg;
		logic        emergency;
		move_t       move_dir, next_move;
		turn_t       turn_dir, next_turn;
		logic [7:0]  speed, turn_speed;
		logic [4:0]  lights;
		logic [31:0] blink_start [3];
		logic [2:0]  blink_armed;
		logic [7:0]  pins, duty;
		drive_res_t  owed [$];
		int          errors;

		function new();
			cfg = '{RESET_BASE_DUTY, RESET_SPEED_STEP, RESET_TURN_STEP, RESET_SPEED_CEIL,
				RESET_SPEED_CEIL, RESET_BLINK_PERIOD};
			emergency = 1'b0;
			move_dir = MOVE_IDLE;
			next_move = MOVE_IDLE;
			turn_dir = TURN_NONE;
			next_turn = TURN_NONE;
			speed = 8'd0;
			turn_speed = 8'd0;
			lights = '0;
			lights[L_HEAD] = 1'b1;
			lights[L_TAIL] = 1'b1;
			foreach (blink_start[i]) blink_start[i] = 32'd0;
			blink_armed = '0;
			pins = 8'd0;
			duty = RESET_BASE_DUTY;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_BASE_DUTY:      cfg.base_duty = val[7:0];
				REG_SPEED_STEP:     cfg.speed_step = val[7:0];
				REG_TURN_STEP:      cfg.turn_step = val[7:0];
				REG_SPEED_CEIL:     cfg.speed_ceil = val[7:0];
				REG_MAX_TURN_SPEED: cfg.max_turn_speed = val[7:0];
				REG_BLINK_PERIOD:   cfg.blink_period = val;
				default: ;
			endcase
		endfunction

		function int waiting();
			return owed.size();
		endfunction

		function bit expired(int t, logic [31:0] now);
			logic [31:0] elapsed;
			elapsed = now - blink_start[t];
			return !blink_armed[t] || elapsed >= {16'd0, cfg.blink_period};
		endfunction

		function void restart(int t, logic [31:0] now);
			blink_start[t] = now;
			blink_armed[t] = 1'b1;
		endfunction

		// The first step from standstill ignores the ceiling.
		function logic [7:0] step_up(logic [7:0] v, logic [7:0] inc, logic [7:0] ceiling);
			logic [8:0] sum;
			if (v == 8'd0) return inc;
			sum = {1'b0, v} + {1'b0, inc};
			if (sum < {1'b0, ceiling}) return sum[7:0];
			return ceiling;
		endfunction

		function logic [7:0] step_down(logic [7:0] v, logic [7:0] dec);
			return (v > dec) ? v - dec : 8'd0;
		endfunction

		function logic [7:0] duty_of(logic [7:0] ramp);
			logic [8:0] d;
			d = {1'b0, cfg.base_duty} + {1'b0, ramp};
			return (d > 9'd255) ? 8'd255 : d[7:0];
		endfunction

		// Returns 1 while emergency mode holds, after this tick's head and tail flash.
		function bit emergency_tick(bit toggle, logic [31:0] now);
			if (toggle) begin
				emergency = !emergency;
				if (emergency) begin
					pins = 8'd0;
					duty = cfg.base_duty;
					speed = 8'd0;
					turn_speed = 8'd0;
					move_dir = MOVE_IDLE;
					next_move = MOVE_IDLE;
					turn_dir = TURN_NONE;
					next_turn = TURN_NONE;
				end else begin
					blink_armed[T_EMERG] = 1'b0;
					lights[L_HEAD] = 1'b1;
					lights[L_TAIL] = 1'b1;
				end
			end
			if (!emergency) return 1'b0;
			if (expired(T_EMERG, now)) begin
				lights[L_HEAD] = !lights[L_HEAD];
				lights[L_TAIL] = !lights[L_TAIL];
				restart(T_EMERG, now);
			end
			return 1'b1;
		endfunction

		function void update_lights(logic [31:0] now);
			bit lwant, rwant;
			lwant = turn_dir == TURN_CCW || move_dir == MOVE_LEFT ||
				move_dir == MOVE_FWD_LEFT || move_dir == MOVE_BACK_LEFT;
			rwant = turn_dir == TURN_CW || move_dir == MOVE_RIGHT ||
				move_dir == MOVE_FWD_RIGHT || move_dir == MOVE_BACK_RIGHT;
			if (lwant && expired(T_LEFT_IND, now)) begin
				lights[L_LEFT] = !lights[L_LEFT];
				restart(T_LEFT_IND, now);
			end else if (rwant && expired(T_RIGHT_IND, now)) begin
				lights[L_RIGHT] = !lights[L_RIGHT];
				restart(T_RIGHT_IND, now);
			end
			// Indicators stay lit only for a current or pending turn.
			if (turn_dir != TURN_CCW && next_turn != TURN_CCW) begin
				lights[L_LEFT] = 1'b0;
				blink_armed[T_LEFT_IND] = 1'b0;
			end
			if (turn_dir != TURN_CW && next_turn != TURN_CW) begin
				lights[L_RIGHT] = 1'b0;
				blink_armed[T_RIGHT_IND] = 1'b0;
			end
			lights[L_BRAKE] = next_move != move_dir;
		endfunction

		function void update_motion();
			if (next_turn != turn_dir)
				turn_speed = step_down(turn_speed, cfg.turn_step);
			else if (turn_dir != TURN_NONE)
				turn_speed = step_up(turn_speed, cfg.turn_step, cfg.max_turn_speed);
			if (next_turn == TURN_NONE) begin
				if (next_move != move_dir)
					speed = step_down(speed, cfg.speed_step);
				else if (move_dir != MOVE_IDLE)
					speed = step_up(speed, cfg.speed_step, cfg.speed_ceil);
				pins = MOVE_PATTERN[next_move];
				duty = (next_move == MOVE_IDLE) ? cfg.base_duty : duty_of(speed);
				if (speed == 8'd0) move_dir = next_move;
			end else begin
				pins = (next_turn == TURN_CW) ? PINS_TURN_CW : PINS_TURN_CCW;
				duty = duty_of(turn_speed);
			end
			if (turn_speed == 8'd0) turn_dir = next_turn;
		endfunction

		function void apply_command(logic [7:0] c, logic [31:0] now);
			logic [7:0] ofs;
			ofs = c - CMD_MOVE_FIRST;
			if (c >= CMD_MOVE_FIRST && c <= CMD_MOVE_LAST) next_move = move_t'(ofs[3:0] + 4'd1);
			else if (c == CMD_TURN_CCW) next_turn = TURN_CCW;
			else if (c == CMD_TURN_CW) next_turn = TURN_CW;
			else if (c == CMD_MOVE_STOP) next_move = MOVE_IDLE;
			else if (c == CMD_TURN_STOP) next_turn = TURN_NONE;
			else if (c == CMD_EMERGENCY) void'(emergency_tick(1'b1, now));
		endfunction

		function void take_tick(tick_req_t t);
			drive_res_t r;
			if (!emergency_tick(t.button_pressed, t.now_ms)) begin
				update_lights(t.now_ms);
				update_motion();
				if (t.cmd_valid) apply_command(t.cmd, t.now_ms);
			end
			r.motor_pins = pins;
			r.duty = duty;
			r.head_light = lights[L_HEAD];
			r.tail_light = lights[L_TAIL];
			r.brake_light = lights[L_BRAKE];
			r.left_indicator = lights[L_LEFT];
			r.right_indicator = lights[L_RIGHT];
			r.emergency_active = emergency;
			owed.push_back(r);
		endfunction

		function string show(drive_res_t r);
			return $sformatf("pins=%h duty=%0d head=%b tail=%b brake=%b left=%b right=%b emerg=%b",
				r.motor_pins, r.duty, r.head_light, r.tail_light, r.brake_light,
				r.left_indicator, r.right_indicator, r.emergency_active);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("%0t: %s", $time, msg);
		endfunction

		function void check_result(drive_res_t got);
			drive_res_t want;
			if (owed.size() == 0) begin
				flag($sformatf("result with no tick waiting: %s", show(got)));
				return;
			end
			want = owed.pop_front();
			if (got !== want)
				flag($sformatf("result mismatch: expected %s, got %s", show(want), show(got)));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	odrc_tick_if   tick_ch();
	odrc_result_if result_ch();

	omni_drive_ramp_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.result    (result_ch)
	);

	drive_tracker tracker;
	bit           send_idle;
	bit           recv_idle;
	int           stall_left = 0;
	logic [31:0]  tick_ms;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int draw_gap(bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic tick_req_t random_tick();
		tick_req_t t;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) tick_ms = $urandom;
		else if (pick < 5) tick_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 80));
		else tick_ms = tick_ms + 32'($urandom_range(0, 60));
		t.now_ms = tick_ms;
		// Leave emergency mode fairly soon so that most ticks exercise the motion logic.
		t.button_pressed = $urandom_range(0, 99) < (tracker.emergency ? 12 : 1);
		t.cmd_valid = 1'b0;
		t.cmd = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			t.cmd_valid = 1'b1;
			case ($urandom_range(0, 11))
				8: t.cmd = CMD_TURN_CCW;
				9: t.cmd = CMD_TURN_CW;
				10: t.cmd = CMD_MOVE_STOP;
				11: t.cmd = CMD_TURN_STOP;
				default: t.cmd = CMD_MOVE_FIRST + 8'($urandom_range(0, 7));
			endcase
		end else if (pick < 23) begin
			t.cmd_valid = 1'b1;
			t.cmd = CMD_EMERGENCY;
		end else if (pick < 27) begin
			t.cmd_valid = 1'b1;
		end
		return t;
	endfunction

	task automatic send_tick(input tick_req_t t);
		int gap;
		gap = draw_gap(send_idle);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			tick_ch.now_ms <= $urandom;
			tick_ch.cmd <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		{tick_ch.now_ms, tick_ch.button_pressed, tick_ch.cmd_valid, tick_ch.cmd} <= t;
		@(posedge clk);
		while (tick_ch.ready !== 1'b1) @(posedge clk);
	endtask

	// Holds off new requests until every owed result has come back.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.waiting() != 0);
	endtask

	task automatic load_settings(input setting_t s);
		logic [CFG_INDEX_W-1:0] regs [6];
		logic [CFG_DATA_W-1:0]  vals [6];
		regs = '{REG_BASE_DUTY, REG_SPEED_STEP, REG_TURN_STEP, REG_SPEED_CEIL,
			REG_MAX_TURN_SPEED, REG_BLINK_PERIOD};
		// Upper bits of the 8-bit registers carry noise that must be dropped.
		vals = '{{8'($urandom), s.base_duty}, {8'($urandom), s.speed_step},
			{8'($urandom), s.turn_step}, {8'($urandom), s.speed_ceil},
			{8'($urandom), s.max_turn_speed}, s.blink_period};
		settle();
		cfg_we <= 1'b1;
		cfg_index <= ($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			tracker.set_reg(regs[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) stall_left = draw_gap(recv_idle);
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
			tracker.take_tick({tick_ch.now_ms, tick_ch.button_pressed, tick_ch.cmd_valid,
				tick_ch.cmd});

	always @(posedge clk)
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			tracker.check_result({result_ch.motor_pins, result_ch.duty, result_ch.head_light,
				result_ch.tail_light, result_ch.brake_light, result_ch.left_indicator,
				result_ch.right_indicator, result_ch.emergency_active});

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		setting_t s;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.now_ms = 32'd0;
		tick_ch.button_pressed = 1'b0;
		tick_ch.cmd_valid = 1'b0;
		tick_ch.cmd = 8'd0;
		result_ch.ready = 1'b0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_TICKS[i]) send_tick(DIRECTED_TICKS[i]);
		tick_ms = 32'h0000_0200;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: s = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF};
				2: s = '0;
				3: s = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 16'($urandom_range(0, 400))};
				4: s = '{RESET_BASE_DUTY, RESET_SPEED_STEP, RESET_TURN_STEP, RESET_SPEED_CEIL,
					RESET_SPEED_CEIL, RESET_BLINK_PERIOD};
				default: s = '{8'($urandom_range(100, 255)), 8'($urandom_range(1, 12)),
					8'($urandom_range(1, 12)), 8'($urandom), 8'($urandom),
					16'($urandom_range(1, 40))};
			endcase
			load_settings(s);
			send_idle = ph != 3;
			recv_idle = ph != 3 && ph != 4;
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 99) == 0) settle();
				send_tick(random_tick());
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.waiting() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
